@@ rtl/lfps_pkg.sv @@
// Shared types, widths, register codes and reset values for the line follower
// steering core. No dependencies; every other file refers to it by scope.
`timescale 1ns / 1ps

package lfps_pkg;

    // field widths
    localparam int GAIN_W    = 23;
    localparam int LIMIT_W   = 15;
    localparam int WEIGHT_W  = 10;
    localparam int SPEED_W   = 8;
    localparam int CORR_W    = 14;
    localparam int SENSOR_COUNT = 4;
    localparam int CFG_IDX_W = 3;

    // internal datapath widths
    localparam int Q_FRAC    = 8;                  // error fraction bits
    localparam int SUM_W     = WEIGHT_W + 2;       // signed sum of active weights
    localparam int MAG_W     = WEIGHT_W + 1;       // its magnitude
    localparam int DIVD_W    = MAG_W + Q_FRAC;     // dividend of the line error divide
    localparam int ERR_W     = WEIGHT_W + Q_FRAC + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int LIM_W     = LIMIT_W + Q_FRAC;
    localparam int INTEG_W   = LIM_W + 1;
    localparam int ACC_W     = INTEG_W + 1;
    localparam int PROD_W    = INTEG_W + 2;        // running partial product
    localparam int STEP_W    = PROD_W + 1;
    localparam int DEN_W     = 3;
    localparam int REM_W     = 2;

    localparam int DIV_STEPS = DIVD_W;
    localparam int MUL_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    localparam logic signed [CORR_W-1:0] CORR_MAX = CORR_W'(8191);
    localparam logic signed [CORR_W-1:0] CORR_MIN = CORR_W'(-8192);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OUTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_INNER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED    = 3'd6;

    // reset values
    localparam logic [GAIN_W-1:0]   RST_GAIN_PROP    = 23'd98304;
    localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG   = 23'd66;
    localparam logic [GAIN_W-1:0]   RST_GAIN_DIFF    = 23'd655360;
    localparam logic [LIMIT_W-1:0]  RST_INTEG_LIMIT  = 15'd1000;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OUTER = 10'd200;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_INNER = 10'd100;
    localparam logic [SPEED_W-1:0]  RST_TOP_SPEED    = 8'd255;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_prop;
        logic [GAIN_W-1:0]   gain_integ;
        logic [GAIN_W-1:0]   gain_diff;
        logic [LIMIT_W-1:0]  integ_limit;
        logic [WEIGHT_W-1:0] weight_outer;
        logic [WEIGHT_W-1:0] weight_inner;
        logic [SPEED_W-1:0]  top_speed;
    } t_cfg;

    // control of a serial unit: load operands, advance one digit
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PID,
        S_MUL,
        S_DONE
    } t_state;

endpackage

@@ rtl/lfps_cfg.sv @@
// Configuration register file of the steering core.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [lfps_pkg::GAIN_W-1:0]    i_data,
    output lfps_pkg::t_cfg                 o_cfg
);

    lfps_pkg::t_cfg r_cfg;
    lfps_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                lfps_pkg::REG_GAIN_PROP:    n_cfg.gain_prop    = i_data;
                lfps_pkg::REG_GAIN_INTEG:   n_cfg.gain_integ   = i_data;
                lfps_pkg::REG_GAIN_DIFF:    n_cfg.gain_diff    = i_data;
                lfps_pkg::REG_INTEG_LIMIT:  n_cfg.integ_limit  = i_data[lfps_pkg::LIMIT_W-1:0];
                lfps_pkg::REG_WEIGHT_OUTER: n_cfg.weight_outer = i_data[lfps_pkg::WEIGHT_W-1:0];
                lfps_pkg::REG_WEIGHT_INNER: n_cfg.weight_inner = i_data[lfps_pkg::WEIGHT_W-1:0];
                lfps_pkg::REG_TOP_SPEED:    n_cfg.top_speed    = i_data[lfps_pkg::SPEED_W-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop    <= lfps_pkg::RST_GAIN_PROP;
            r_cfg.gain_integ   <= lfps_pkg::RST_GAIN_INTEG;
            r_cfg.gain_diff    <= lfps_pkg::RST_GAIN_DIFF;
            r_cfg.integ_limit  <= lfps_pkg::RST_INTEG_LIMIT;
            r_cfg.weight_outer <= lfps_pkg::RST_WEIGHT_OUTER;
            r_cfg.weight_inner <= lfps_pkg::RST_WEIGHT_INNER;
            r_cfg.top_speed    <= lfps_pkg::RST_TOP_SPEED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/lfps_div.sv @@
// Bit-serial restoring divider for the line error: magnitude over sensor count.
// One quotient bit per step. Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_div (
    input  logic                           i_clk,
    input  lfps_pkg::t_ser_ctl             i_ctl,
    input  logic [lfps_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [lfps_pkg::DEN_W-1:0]     i_divisor,
    output logic [lfps_pkg::DIVD_W-1:0]    o_quot
);

    logic [lfps_pkg::DIVD_W-1:0] r_num, n_num;
    logic [lfps_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [lfps_pkg::DEN_W-1:0]  r_den, n_den;
    logic [lfps_pkg::DEN_W-1:0]  w_trial;
    logic [lfps_pkg::DEN_W-1:0]  w_diff;
    logic                        w_ge;

    // remainder stays below the divisor (at most 4), so two bits hold it
    assign w_trial = {r_rem, r_num[lfps_pkg::DIVD_W-1]};
    assign w_ge    = (w_trial >= r_den);
    assign w_diff  = w_trial - r_den;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        n_den = r_den;
        if (i_ctl.load) begin
            n_num = i_dividend;
            n_rem = '0;
            n_den = i_divisor;
        end else if (i_ctl.step) begin
            n_num = {r_num[lfps_pkg::DIVD_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[lfps_pkg::REM_W-1:0] : w_trial[lfps_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quot = r_num;

endmodule

@@ rtl/lfps_mac.sv @@
// Bit-serial sum of three products gain*operand, one gain bit per step.
// Partial product shifts right; bits shifted out fold into a sticky flag.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_mac (
    input  logic                                  i_clk,
    input  lfps_pkg::t_ser_ctl                    i_ctl,
    input  lfps_pkg::t_cfg                        i_cfg,
    input  logic signed [lfps_pkg::ERR_W-1:0]     i_err,
    input  logic signed [lfps_pkg::INTEG_W-1:0]   i_integ,
    input  logic signed [lfps_pkg::DIFF_W-1:0]    i_diff,
    output logic signed [lfps_pkg::PROD_W-1:0]    o_prod,
    output logic                                  o_sticky
);

    logic signed [lfps_pkg::ERR_W-1:0]   r_err;
    logic signed [lfps_pkg::INTEG_W-1:0] r_integ;
    logic signed [lfps_pkg::DIFF_W-1:0]  r_diff;
    logic [lfps_pkg::GAIN_W-1:0]         r_gp, r_gi, r_gd;
    logic signed [lfps_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                                r_sticky, n_sticky;
    logic signed [lfps_pkg::STEP_W-1:0]  w_add;
    logic signed [lfps_pkg::STEP_W-1:0]  w_sum;

    always_comb begin
        w_add = '0;
        if (r_gp[0]) w_add = w_add + lfps_pkg::STEP_W'(r_err);
        if (r_gi[0]) w_add = w_add + lfps_pkg::STEP_W'(r_integ);
        if (r_gd[0]) w_add = w_add + lfps_pkg::STEP_W'(r_diff);
        w_sum = lfps_pkg::STEP_W'(r_prod) + w_add;
    end

    always_comb begin
        n_prod   = r_prod;
        n_sticky = r_sticky;
        if (i_ctl.load) begin
            n_prod   = '0;
            n_sticky = 1'b0;
        end else if (i_ctl.step) begin
            n_prod   = w_sum[lfps_pkg::STEP_W-1:1];
            n_sticky = r_sticky | w_sum[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_sticky <= n_sticky;
        if (i_ctl.load) begin
            r_err   <= i_err;
            r_integ <= i_integ;
            r_diff  <= i_diff;
            r_gp    <= i_cfg.gain_prop;
            r_gi    <= i_cfg.gain_integ;
            r_gd    <= i_cfg.gain_diff;
        end else if (i_ctl.step) begin
            r_gp <= r_gp >> 1;
            r_gi <= r_gi >> 1;
            r_gd <= r_gd >> 1;
        end
    end

    assign o_prod   = r_prod;
    assign o_sticky = r_sticky;

endmodule

@@ rtl/line_follower_pid_steering_core.sv @@
// Line follower steering core: top level with the control sequencer and PID state.
// Depends on lfps_pkg, lfps_cfg, lfps_div and lfps_mac.
//
// Use: one input transfer per control tick (button level, four line sensors),
// one result transfer per tick (motors_on, left/right speed, correction).
// Registers are written on the cfg channel (index, data), always ready; the user
// must write them only while idle, which the core itself does not enforce.
// Work per tick, accept to next accept:
//   - control tick with at least one sensor active: the 19-step serial divide,
//     the PID state update and the 23-step serial multiply over the gain bits;
//   - control tick with no sensor active: the same with the divide skipped;
//   - toggle or stopped tick: straight to the result, no arithmetic.
// The result lands in an output register; the core takes no new item until it
// has loaded that register, and waits in its final state while the receiver
// stalls with an older result still held.
// Reset (synchronous, active low): stopped, button released, error and
// integral zero, registers at their default values, no result pending.
`timescale 1ns / 1ps

module line_follower_pid_steering_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfps_pkg::GAIN_W-1:0]          i_cfg_data,
    // input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_button_level,
    input  logic [lfps_pkg::SENSOR_COUNT-1:0]    i_sensor_bits,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_motors_on,
    output logic [lfps_pkg::SPEED_W-1:0]         o_left_speed,
    output logic [lfps_pkg::SPEED_W-1:0]         o_right_speed,
    output logic signed [lfps_pkg::CORR_W-1:0]   o_correction
);

    localparam int CNT_W = lfps_pkg::CNT_W;

    lfps_pkg::t_cfg     w_cfg;
    lfps_pkg::t_ser_ctl w_div_ctl;
    lfps_pkg::t_ser_ctl w_mac_ctl;

    lfps_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_run, r_btn_prev, r_do_step, r_neg, r_none;
    logic signed [lfps_pkg::ERR_W-1:0]   r_err_prev;
    logic signed [lfps_pkg::INTEG_W-1:0] r_integ;
    logic             r_out_valid;
    logic             r_motors_on;
    logic [lfps_pkg::SPEED_W-1:0]        r_left, r_right;
    logic signed [lfps_pkg::CORR_W-1:0]  r_corr;

    logic w_accept, w_edge, w_out_load, w_in_ready;

    // ---------------- configuration
    assign o_cfg_ready = 1'b1;

    lfps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // ---------------- sensor weights: -outer, -inner, +inner, +outer
    logic signed [lfps_pkg::SUM_W-1:0] w_wo, w_wi, w_sum, w_sum_abs;
    logic [lfps_pkg::DEN_W-1:0]        w_count;
    logic [lfps_pkg::DIVD_W-1:0]       w_dividend;

    always_comb begin
        w_wo  = $signed({2'b00, w_cfg.weight_outer});
        w_wi  = $signed({2'b00, w_cfg.weight_inner});
        w_sum = '0;
        if (i_sensor_bits[0]) w_sum = w_sum - w_wo;
        if (i_sensor_bits[1]) w_sum = w_sum - w_wi;
        if (i_sensor_bits[2]) w_sum = w_sum + w_wi;
        if (i_sensor_bits[3]) w_sum = w_sum + w_wo;
        w_sum_abs  = w_sum[lfps_pkg::SUM_W-1] ? -w_sum : w_sum;
        w_count    = lfps_pkg::DEN_W'(i_sensor_bits[0]) + lfps_pkg::DEN_W'(i_sensor_bits[1])
                   + lfps_pkg::DEN_W'(i_sensor_bits[2]) + lfps_pkg::DEN_W'(i_sensor_bits[3]);
        w_dividend = {w_sum_abs[lfps_pkg::MAG_W-1:0], {lfps_pkg::Q_FRAC{1'b0}}};
    end

    logic [lfps_pkg::DIVD_W-1:0] w_quot;

    lfps_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_count),
        .o_quot     (w_quot)
    );

    // ---------------- PID state update
    logic signed [lfps_pkg::ERR_W-1:0]   w_qs, w_err;
    logic signed [lfps_pkg::ACC_W-1:0]   w_acc, w_lim;
    logic signed [lfps_pkg::INTEG_W-1:0] w_integ_new;
    logic signed [lfps_pkg::DIFF_W-1:0]  w_diff;

    always_comb begin
        // quotient is at most 1023*256, so its top bit is always clear
        w_qs  = $signed({1'b0, w_quot[lfps_pkg::ERR_W-2:0]});
        w_err = r_none ? r_err_prev : (r_neg ? -w_qs : w_qs);
        w_acc = lfps_pkg::ACC_W'(r_integ) + lfps_pkg::ACC_W'(w_err);
        w_lim = $signed({2'b00, w_cfg.integ_limit, {lfps_pkg::Q_FRAC{1'b0}}});
        if (w_acc > w_lim) begin
            w_integ_new = w_lim[lfps_pkg::INTEG_W-1:0];
        end else if (w_acc < -w_lim) begin
            w_integ_new = lfps_pkg::INTEG_W'(-w_lim);
        end else begin
            w_integ_new = w_acc[lfps_pkg::INTEG_W-1:0];
        end
        w_diff = lfps_pkg::DIFF_W'(w_err) - lfps_pkg::DIFF_W'(r_err_prev);
    end

    logic signed [lfps_pkg::PROD_W-1:0] w_prod;
    logic                               w_sticky;

    lfps_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_cfg    (w_cfg),
        .i_err    (w_err),
        .i_integ  (w_integ_new),
        .i_diff   (w_diff),
        .o_prod   (w_prod),
        .o_sticky (w_sticky)
    );

    // ---------------- correction and wheel speeds
    // total = prod*2^23 + dropped bits; divide by 2^24 rounding toward zero
    logic signed [lfps_pkg::PROD_W-2:0] w_qfl, w_q;
    logic signed [lfps_pkg::CORR_W-1:0] w_corr;
    logic [lfps_pkg::CORR_W-1:0]        w_mag;
    logic [lfps_pkg::SPEED_W-1:0]       w_slow, w_left, w_right;

    always_comb begin
        w_qfl = w_prod[lfps_pkg::PROD_W-1:1];
        w_q   = w_qfl + (lfps_pkg::PROD_W-1)'(w_prod[lfps_pkg::PROD_W-1]
                                               & (w_prod[0] | w_sticky));
        if (w_q > (lfps_pkg::PROD_W-1)'(lfps_pkg::CORR_MAX)) begin
            w_corr = lfps_pkg::CORR_MAX;
        end else if (w_q < (lfps_pkg::PROD_W-1)'(lfps_pkg::CORR_MIN)) begin
            w_corr = lfps_pkg::CORR_MIN;
        end else begin
            w_corr = w_q[lfps_pkg::CORR_W-1:0];
        end
        w_mag  = w_corr[lfps_pkg::CORR_W-1] ? lfps_pkg::CORR_W'(-w_corr)
                                            : lfps_pkg::CORR_W'(w_corr);
        w_slow = (w_mag >= lfps_pkg::CORR_W'(w_cfg.top_speed))
               ? '0 : w_cfg.top_speed - w_mag[lfps_pkg::SPEED_W-1:0];
        w_left  = w_corr[lfps_pkg::CORR_W-1] ? w_slow : w_cfg.top_speed;
        w_right = (w_corr > 0) ? w_slow : w_cfg.top_speed;
    end

    // ---------------- sequencer
    assign w_edge   = i_button_level & ~r_btn_prev;
    assign w_accept = i_in_valid & w_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (!w_edge && r_run) begin
                        n_state = (w_count == '0) ? lfps_pkg::S_PID : lfps_pkg::S_DIV;
                    end else begin
                        n_state = lfps_pkg::S_DONE;
                    end
                end
            end
            lfps_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(lfps_pkg::DIV_STEPS - 1)) n_state = lfps_pkg::S_PID;
            end
            lfps_pkg::S_PID:  n_state = lfps_pkg::S_MUL;
            lfps_pkg::S_MUL: begin
                if (r_cnt == CNT_W'(lfps_pkg::MUL_STEPS - 1)) n_state = lfps_pkg::S_DONE;
            end
            lfps_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = lfps_pkg::S_IDLE;
            end
            default: n_state = lfps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready     = 1'b0;
        w_out_load     = 1'b0;
        w_div_ctl      = '0;
        w_mac_ctl      = '0;
        n_cnt          = '0;
        unique case (r_state)
            lfps_pkg::S_IDLE: begin
                w_in_ready     = 1'b1;
                w_div_ctl.load = i_in_valid;
            end
            lfps_pkg::S_DIV: begin
                w_div_ctl.step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            lfps_pkg::S_PID: begin
                w_mac_ctl.load = 1'b1;
            end
            lfps_pkg::S_MUL: begin
                w_mac_ctl.step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            lfps_pkg::S_DONE: begin
                w_out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfps_pkg::S_IDLE;
            r_cnt       <= '0;
            r_run       <= 1'b0;
            r_btn_prev  <= 1'b0;
            r_do_step   <= 1'b0;
            r_err_prev  <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_accept) begin
                r_btn_prev <= i_button_level;
                r_do_step  <= !w_edge && r_run;
                if (w_edge) r_run <= !r_run;
            end
            if (r_state == lfps_pkg::S_PID) begin
                r_err_prev <= w_err;
                r_integ    <= w_integ_new;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg  <= w_sum[lfps_pkg::SUM_W-1];
            r_none <= (w_count == '0);
        end
        if (w_out_load) begin
            r_motors_on <= r_run;
            r_left      <= r_do_step ? w_left  : '0;
            r_right     <= r_do_step ? w_right : '0;
            r_corr      <= r_do_step ? w_corr  : '0;
        end
    end

    assign o_in_ready    = w_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_motors_on   = r_motors_on;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_correction  = r_corr;

endmodule

@@ bench/lfps_steer_checker.sv @@
// Checker for the line follower steering core: watches the register, tick and
// wheel command channels, predicts each command and compares it. Needs lfps_pkg.
`timescale 1ns / 1ps

module lfps_steer_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfps_pkg::GAIN_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_button_level,
    input  logic [lfps_pkg::SENSOR_COUNT-1:0]    i_sensor_bits,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic                                 i_motors_on,
    input  logic [lfps_pkg::SPEED_W-1:0]         i_left_speed,
    input  logic [lfps_pkg::SPEED_W-1:0]         i_right_speed,
    input  logic signed [lfps_pkg::CORR_W-1:0]   i_correction,
    output int                                   o_pending,
    output int                                   o_fail_count
);

    typedef struct packed {
        logic                                motors_on;
        logic [lfps_pkg::SPEED_W-1:0]        left_speed;
        logic [lfps_pkg::SPEED_W-1:0]        right_speed;
        logic signed [lfps_pkg::CORR_W-1:0]  correction;
    } t_wheel_cmd;

    localparam int MAX_LINES = 40;

    t_wheel_cmd     wheel_cmd_q[$];
    lfps_pkg::t_cfg cfg_now;
    logic           run_on;
    logic           btn_last;
    int             err_last;
    int             integ;
    int             mismatches;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        mismatches   = 0;
    end

    task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        if (mismatches < MAX_LINES)
            $display("%0t checker: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // weighted mean of the active sensors in Q.8; no sensor keeps the last error
    function automatic int line_err(input logic [lfps_pkg::SENSOR_COUNT-1:0] bits);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        if (bits[0]) begin sum -= int'(cfg_now.weight_outer); cnt++; end
        if (bits[1]) begin sum -= int'(cfg_now.weight_inner); cnt++; end
        if (bits[2]) begin sum += int'(cfg_now.weight_inner); cnt++; end
        if (bits[3]) begin sum += int'(cfg_now.weight_outer); cnt++; end
        if (cnt == 0)
            return err_last;
        return (sum * 256) / cnt;
    endfunction

    function automatic logic [lfps_pkg::SPEED_W-1:0] clamp_speed(input int v);
        if (v < 0)
            return '0;
        if (v > int'(cfg_now.top_speed))
            return cfg_now.top_speed;
        return lfps_pkg::SPEED_W'(v);
    endfunction

    task automatic steer_tick(input logic btn, input logic [lfps_pkg::SENSOR_COUNT-1:0] bits,
                              output t_wheel_cmd cmd);
        logic   edge_seen;
        int     err;
        int     lim;
        int     corr;
        int     top;
        longint total;
        longint q;
        edge_seen = btn && !btn_last;
        btn_last  = btn;
        corr      = 0;
        cmd       = '0;
        if (edge_seen) begin
            run_on = !run_on;
        end else if (run_on) begin
            err = line_err(bits);
            lim = int'(cfg_now.integ_limit) * 256;
            integ += err;
            if (integ > lim)
                integ = lim;
            if (integ < -lim)
                integ = -lim;
            total = longint'(cfg_now.gain_prop) * err
                  + longint'(cfg_now.gain_integ) * integ
                  + longint'(cfg_now.gain_diff) * (longint'(err) - err_last);
            err_last = err;
            q = total / (longint'(1) << 24);   // truncates toward zero
            if (q > longint'(lfps_pkg::CORR_MAX))
                q = longint'(lfps_pkg::CORR_MAX);
            if (q < longint'(lfps_pkg::CORR_MIN))
                q = longint'(lfps_pkg::CORR_MIN);
            corr = int'(q);
            top  = int'(cfg_now.top_speed);
            if (corr > 0) begin
                cmd.left_speed  = clamp_speed(top);
                cmd.right_speed = clamp_speed(top - corr);
            end else begin
                cmd.left_speed  = clamp_speed(top + corr);
                cmd.right_speed = clamp_speed(top);
            end
        end
        cmd.motors_on  = run_on;
        cmd.correction = lfps_pkg::CORR_W'(corr);
    endtask

    always @(posedge i_clk) begin
        t_wheel_cmd want;
        t_wheel_cmd next_cmd;
        if (!i_rst_n) begin
            wheel_cmd_q.delete();
            cfg_now  = '{gain_prop:    lfps_pkg::RST_GAIN_PROP,
                         gain_integ:   lfps_pkg::RST_GAIN_INTEG,
                         gain_diff:    lfps_pkg::RST_GAIN_DIFF,
                         integ_limit:  lfps_pkg::RST_INTEG_LIMIT,
                         weight_outer: lfps_pkg::RST_WEIGHT_OUTER,
                         weight_inner: lfps_pkg::RST_WEIGHT_INNER,
                         top_speed:    lfps_pkg::RST_TOP_SPEED};
            run_on   = 1'b0;
            btn_last = 1'b0;
            err_last = 0;
            integ    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lfps_pkg::REG_GAIN_PROP:    cfg_now.gain_prop    = i_cfg_data;
                    lfps_pkg::REG_GAIN_INTEG:   cfg_now.gain_integ   = i_cfg_data;
                    lfps_pkg::REG_GAIN_DIFF:    cfg_now.gain_diff    = i_cfg_data;
                    lfps_pkg::REG_INTEG_LIMIT:
                        cfg_now.integ_limit  = i_cfg_data[lfps_pkg::LIMIT_W-1:0];
                    lfps_pkg::REG_WEIGHT_OUTER:
                        cfg_now.weight_outer = i_cfg_data[lfps_pkg::WEIGHT_W-1:0];
                    lfps_pkg::REG_WEIGHT_INNER:
                        cfg_now.weight_inner = i_cfg_data[lfps_pkg::WEIGHT_W-1:0];
                    lfps_pkg::REG_TOP_SPEED:
                        cfg_now.top_speed    = i_cfg_data[lfps_pkg::SPEED_W-1:0];
                    default: ;
                endcase
            end
            // a result transfer always belongs to an older tick than one taken now
            if (i_out_valid && i_out_ready) begin
                if (wheel_cmd_q.size() == 0) begin
                    flag_mismatch("command with no tick outstanding", i_correction, '0);
                end else begin
                    want = wheel_cmd_q.pop_front();
                    if (i_motors_on !== want.motors_on)
                        flag_mismatch("motors_on", i_motors_on, want.motors_on);
                    if (i_left_speed !== want.left_speed)
                        flag_mismatch("left_speed", i_left_speed, want.left_speed);
                    if (i_right_speed !== want.right_speed)
                        flag_mismatch("right_speed", i_right_speed, want.right_speed);
                    if (i_correction !== want.correction)
                        flag_mismatch("correction", i_correction, want.correction);
                end
            end
            if (i_in_valid && i_in_ready) begin
                steer_tick(i_button_level, i_sensor_bits, next_cmd);
                wheel_cmd_q.push_back(next_cmd);
            end
        end
        o_pending    <= wheel_cmd_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ bench/line_follower_pid_steering_core_tb.sv @@
// Testbench top for the line follower steering core: clock, reset, register
// writes, tick and back-pressure stimulus, verdict. Needs lfps_pkg, lfps_steer_checker.
`timescale 1ns / 1ps

module line_follower_pid_steering_core_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [lfps_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // directed ticks, {button, sensors}, first entry leftmost
    localparam int DIR_COUNT = 24;
    localparam logic [DIR_COUNT*5-1:0] DIR_TICKS = {
        5'b0_0000, 5'b1_0000, 5'b1_0001, 5'b0_1000, 5'b0_0010, 5'b0_0100,
        5'b0_0110, 5'b0_1111, 5'b0_0000, 5'b0_1001, 5'b0_0011, 5'b0_1100,
        5'b0_0111, 5'b0_1110, 5'b0_0101, 5'b0_1010, 5'b0_1011, 5'b0_1101,
        5'b1_0011, 5'b0_0011, 5'b1_0000, 5'b1_0001, 5'b0_0000, 5'b0_1000
    };

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [lfps_pkg::GAIN_W-1:0]          i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic                                 i_button_level;
    logic [lfps_pkg::SENSOR_COUNT-1:0]    i_sensor_bits;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic                                 o_motors_on;
    logic [lfps_pkg::SPEED_W-1:0]         o_left_speed;
    logic [lfps_pkg::SPEED_W-1:0]         o_right_speed;
    logic signed [lfps_pkg::CORR_W-1:0]   o_correction;

    int   pending;
    int   fail_count;
    int   cycles = 0;
    bit   idle_on = 1'b0;
    logic run_guess = 1'b0;
    logic btn_held = 1'b0;
    logic [lfps_pkg::SENSOR_COUNT-1:0] bits_last = '0;

    line_follower_pid_steering_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_button_level(i_button_level),
        .i_sensor_bits (i_sensor_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_motors_on   (o_motors_on),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .o_correction  (o_correction)
    );

    lfps_steer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_button_level(i_button_level),
        .i_sensor_bits (i_sensor_bits),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_motors_on   (o_motors_on),
        .i_left_speed  (o_left_speed),
        .i_right_speed (o_right_speed),
        .i_correction  (o_correction),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure: random stalls, only while idle_on is set
    initial begin
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                stall = $urandom_range(1, 14) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [lfps_pkg::GAIN_W-1:0] rand_gain();
        return lfps_pkg::GAIN_W'($urandom_range(0, 8388607) >> $urandom_range(0, 14));
    endfunction

    // valid stays high across back-to-back ticks; it is only lowered for a gap
    task automatic push_tick(input logic btn, input logic [lfps_pkg::SENSOR_COUNT-1:0] bits);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_button_level <= btn;
        i_sensor_bits  <= bits;
        do @(posedge i_clk); while (!o_in_ready);
        if (btn && !btn_held)
            run_guess = !run_guess;
        btn_held  = btn;
        bits_last = bits;
    endtask

    // hold the sender off until every outstanding command has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfps_pkg::GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_all(input logic [lfps_pkg::GAIN_W-1:0] gp,
                             input logic [lfps_pkg::GAIN_W-1:0] gi,
                             input logic [lfps_pkg::GAIN_W-1:0] gd,
                             input logic [lfps_pkg::LIMIT_W-1:0] lim,
                             input logic [lfps_pkg::WEIGHT_W-1:0] w_out,
                             input logic [lfps_pkg::WEIGHT_W-1:0] w_in,
                             input logic [lfps_pkg::SPEED_W-1:0] top);
        write_reg(lfps_pkg::REG_GAIN_PROP, gp);
        write_reg(lfps_pkg::REG_GAIN_INTEG, gi);
        write_reg(lfps_pkg::REG_GAIN_DIFF, gd);
        write_reg(lfps_pkg::REG_INTEG_LIMIT, lfps_pkg::GAIN_W'(lim));
        write_reg(lfps_pkg::REG_WEIGHT_OUTER, lfps_pkg::GAIN_W'(w_out));
        write_reg(lfps_pkg::REG_WEIGHT_INNER, lfps_pkg::GAIN_W'(w_in));
        write_reg(lfps_pkg::REG_TOP_SPEED, lfps_pkg::GAIN_W'(top));
        // unused index, must leave every register alone
        write_reg(REG_UNUSED, lfps_pkg::GAIN_W'($urandom_range(0, 8388607)));
        i_cfg_valid <= 1'b0;
    endtask

    // mostly running ticks; presses are rare while running, likely while stopped
    task automatic random_ticks(input int count);
        int                                k;
        logic                              btn;
        logic [lfps_pkg::SENSOR_COUNT-1:0] bits;
        for (k = 0; k < count; k++) begin
            if (btn_held)
                btn = 1'($urandom_range(0, 1));
            else if (run_guess)
                btn = ($urandom_range(0, 24) == 0);
            else
                btn = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 7))
                0, 1:    bits = bits_last;
                2:       bits = '0;
                default: bits = lfps_pkg::SENSOR_COUNT'($urandom_range(0, 15));
            endcase
            push_tick(btn, bits);
        end
    endtask

    initial begin
        int                k;
        logic [4:0]        entry;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_button_level <= 1'b0;
        i_sensor_bits  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        for (k = 0; k < DIR_COUNT; k++) begin
            entry = DIR_TICKS[(DIR_COUNT-1-k)*5 +: 5];
            push_tick(entry[4], entry[3:0]);
        end

        settle();
        write_all('1, '1, '1, '1, '1, '1, '1);
        random_ticks(60);

        settle();
        write_all('0, '0, '0, '0, '0, '0, '0);
        random_ticks(40);

        // near-default tuning, tight integral clamp, no idling
        settle();
        idle_on = 1'b0;
        write_all(lfps_pkg::GAIN_W'($urandom_range(0, 200000)),
                  lfps_pkg::GAIN_W'($urandom_range(0, 5000)),
                  lfps_pkg::GAIN_W'($urandom_range(0, 1000000)),
                  lfps_pkg::LIMIT_W'($urandom_range(0, 20)),
                  lfps_pkg::WEIGHT_W'($urandom_range(0, 1023)),
                  lfps_pkg::WEIGHT_W'($urandom_range(0, 1023)),
                  lfps_pkg::SPEED_W'($urandom_range(0, 255)));
        random_ticks(70);

        idle_on = 1'b1;
        for (k = 0; k < 5; k++) begin
            settle();
            write_all(rand_gain(), rand_gain(), rand_gain(),
                      lfps_pkg::LIMIT_W'($urandom_range(0, 32767) >> $urandom_range(0, 10)),
                      lfps_pkg::WEIGHT_W'($urandom_range(0, 1023)),
                      lfps_pkg::WEIGHT_W'($urandom_range(0, 1023)),
                      lfps_pkg::SPEED_W'($urandom_range(0, 255)));
            random_ticks(60);
        end

        settle();
        idle_on = 1'b0;
        write_all(lfps_pkg::RST_GAIN_PROP, lfps_pkg::RST_GAIN_INTEG, lfps_pkg::RST_GAIN_DIFF,
                  lfps_pkg::RST_INTEG_LIMIT, lfps_pkg::RST_WEIGHT_OUTER,
                  lfps_pkg::RST_WEIGHT_INNER, lfps_pkg::RST_TOP_SPEED);
        random_ticks(40);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/lfps_pkg.sv
rtl/lfps_cfg.sv
rtl/lfps_div.sv
rtl/lfps_mac.sv
rtl/line_follower_pid_steering_core.sv
bench/lfps_steer_checker.sv
bench/line_follower_pid_steering_core_tb.sv
